FILE: hw/rtl/hbbsd_pkg.sv
// ----------------------------------------------------------------------------
// hbbsd_pkg
// Shared types and constants for the heater bang-bang controller with
// settle detection: configuration register map, reset values, and the
// request struct passed to the settle detector.
// ----------------------------------------------------------------------------
package hbbsd_pkg;

    // Configuration port geometry
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TEMP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_SPAN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WARM_LEVEL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 3'd5;

    // Reset values (0.01 degC units, ticks)
    localparam logic signed [15:0] RST_TARGET_TEMP    = 16'sd5600;
    localparam logic [14:0]        RST_WARMUP_SPAN    = 15'd800;
    localparam logic [14:0]        RST_HYSTERESIS     = 15'd100;
    localparam logic signed [15:0] RST_WARM_LEVEL     = 16'sd3800;
    localparam logic [15:0]        RST_SLOPE_LIMIT    = 16'd10;
    localparam logic [15:0]        RST_TIMEOUT_TICKS  = 16'd600;

    // Tick counter saturation value
    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    // Live configuration
    typedef struct packed {
        logic signed [15:0] target_temp;
        logic [14:0]        warmup_span;
        logic [14:0]        hysteresis;
        logic signed [15:0] warm_level;
        logic [15:0]        slope_limit;
        logic [15:0]        timeout_ticks;
    } t_cfg;

    // One tick's request to the settle detector
    typedef struct packed {
        logic               step;     // tick is committed this cycle
        logic               near;     // temperature at or above preheat threshold
        logic               in_band;  // temperature at or above target - hysteresis
        logic signed [15:0] temp;
    } t_settle_req;

endpackage

FILE: hw/rtl/hbbsd_cfg_regs.sv
// ----------------------------------------------------------------------------
// hbbsd_cfg_regs
// Configuration register file. Plain write port, no read-back; writes to
// unused indexes are dropped.
// ----------------------------------------------------------------------------
module hbbsd_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hbbsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hbbsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output hbbsd_pkg::t_cfg                  o_cfg
);
    import hbbsd_pkg::*;

    t_cfg r_cfg;

    // Register writes; upper bits of narrow registers are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_temp    <= RST_TARGET_TEMP;
            r_cfg.warmup_span    <= RST_WARMUP_SPAN;
            r_cfg.hysteresis     <= RST_HYSTERESIS;
            r_cfg.warm_level     <= RST_WARM_LEVEL;
            r_cfg.slope_limit    <= RST_SLOPE_LIMIT;
            r_cfg.timeout_ticks  <= RST_TIMEOUT_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET_TEMP:    r_cfg.target_temp    <= i_cfg_data;
                CFG_WARMUP_SPAN:    r_cfg.warmup_span    <= i_cfg_data[14:0];
                CFG_HYSTERESIS:     r_cfg.hysteresis     <= i_cfg_data[14:0];
                CFG_WARM_LEVEL:     r_cfg.warm_level     <= i_cfg_data;
                CFG_SLOPE_LIMIT:    r_cfg.slope_limit    <= i_cfg_data;
                CFG_TIMEOUT_TICKS:  r_cfg.timeout_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/hbbsd_settle.sv
// ----------------------------------------------------------------------------
// hbbsd_settle
// Settle detector: records deltas between successive near-target samples
// in a ring, checks every delta magnitude against the slope limit in
// parallel, and holds the sticky ready flag and saturating tick counter.
// ----------------------------------------------------------------------------
module hbbsd_settle #(
    parameter int SLOPE_WINDOW = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  hbbsd_pkg::t_settle_req i_req,
    input  logic [15:0]            i_slope_limit,
    input  logic [15:0]            i_timeout_ticks,
    output logic                   o_ready_next
);
    import hbbsd_pkg::*;

    localparam int PTR_W = (SLOPE_WINDOW > 1) ? $clog2(SLOPE_WINDOW) : 1;
    localparam int CNT_W = $clog2(SLOPE_WINDOW + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SLOPE_WINDOW - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOPE_WINDOW);

    logic signed [16:0] r_ring [SLOPE_WINDOW];
    logic [PTR_W-1:0]   r_ptr;
    logic [CNT_W-1:0]   r_cnt;
    logic signed [15:0] r_prev_temp;
    logic               r_prev_valid;
    logic               r_ready;
    logic [15:0]        r_ticks;

    logic [PTR_W-1:0]   n_ptr;
    logic [CNT_W-1:0]   n_cnt;
    logic [15:0]        n_ticks;

    logic               track;
    logic               wr;
    logic signed [16:0] delta;
    logic signed [16:0] ring_view [SLOPE_WINDOW];
    logic [16:0]        mag [SLOPE_WINDOW];
    logic [SLOPE_WINDOW-1:0] entry_ok;
    logic               window_calm;
    logic               tick_expired;

    // Delta tracking runs only before ready and while near target
    assign track = !r_ready && i_req.near;
    assign wr    = track && r_prev_valid;
    assign delta = {i_req.temp[15], i_req.temp} - {r_prev_temp[15], r_prev_temp};

    // Ring contents after this tick's write, and per-entry limit check
    always_comb begin
        for (int i = 0; i < SLOPE_WINDOW; i++) begin
            ring_view[i] = (wr && r_ptr == PTR_W'(i)) ? delta : r_ring[i];
            mag[i]       = ring_view[i][16] ? 17'(-ring_view[i]) : 17'(ring_view[i]);
            entry_ok[i]  = mag[i] < {1'b0, i_slope_limit};
        end
    end

    // Pointer, fill count and tick counter next values
    assign n_ptr   = !wr ? r_ptr : ((r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1);
    assign n_cnt   = (wr && r_cnt != CNT_FULL) ? r_cnt + 1'b1 : r_cnt;
    assign n_ticks = (r_ticks == TICK_MAX) ? r_ticks : r_ticks + 16'd1;

    // Ready decision uses the window as updated by this tick
    assign window_calm  = (n_cnt == CNT_FULL) && (&entry_ok);
    assign tick_expired = r_ticks >= i_timeout_ticks;
    assign o_ready_next = r_ready || (i_req.in_band && window_calm) || tick_expired;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr        <= '0;
            r_cnt        <= '0;
            r_prev_valid <= 1'b0;
            r_ready      <= 1'b0;
            r_ticks      <= '0;
        end else if (i_req.step) begin
            r_ptr   <= n_ptr;
            r_cnt   <= n_cnt;
            r_ready <= o_ready_next;
            r_ticks <= n_ticks;
            if (track) begin
                r_prev_valid <= 1'b1;
            end
        end
    end

    // Payload: ring entries and previous sample
    always_ff @(posedge i_clk) begin
        if (i_req.step) begin
            for (int i = 0; i < SLOPE_WINDOW; i++) begin
                r_ring[i] <= ring_view[i];
            end
            if (track) begin
                r_prev_temp <= i_req.temp;
            end
        end
    end

endmodule

FILE: hw/rtl/heater_bang_bang_with_settle_detect_top.sv
// ----------------------------------------------------------------------------
// heater_bang_bang_with_settle_detect_top
// Each transaction is one control tick carrying a signed temperature in
// 0.01 degC units; each produces one result transaction with the heater
// drive and the warm, ready and near-target flags after that tick. The
// block takes one transaction per clock unless stalled: a tick passes from
// the input register through one level of compare logic (threshold compares
// and a parallel check of all SLOPE_WINDOW stored deltas) into the result
// register, which presents it as valid until it is taken; throughput is
// one tick per cycle as long as results are taken. While a result waits,
// the input register can still take one more tick; input ready then stays
// low until the result is taken. Configuration registers may be written
// while no tick is in flight; writes take effect once registered.
// ----------------------------------------------------------------------------
module heater_bang_bang_with_settle_detect_top #(
    parameter int SLOPE_WINDOW = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [hbbsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hbbsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [15:0]               i_temperature,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_heater_on,
    output logic                             o_warm,
    output logic                             o_ready_res,
    output logic                             o_near_setpt
);
    import hbbsd_pkg::*;

    t_cfg               cfg;
    t_settle_req        settle_req;
    logic               ready_next;

    logic               r_in_valid;
    logic signed [15:0] r_in_temp;
    logic               r_out_valid;
    logic               r_heater;
    logic               r_warm;
    logic               r_out_heater;
    logic               r_out_warm;
    logic               r_out_ready;
    logic               r_out_near;

    logic               n_heater;
    logic               n_warm;
    logic               advance;

    logic signed [17:0] t_x;
    logic signed [17:0] tgt_x;
    logic signed [17:0] warm_x;
    logic signed [17:0] near_lo;
    logic signed [17:0] band_lo;
    logic signed [17:0] band_hi;
    logic               near;

    hbbsd_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Handshake: the held tick moves on when the result slot is free or
    // being drained
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_temp <= i_temperature;
        end
    end

    // Thresholds at full precision, no wrap
    assign t_x     = {{2{r_in_temp[15]}}, r_in_temp};
    assign tgt_x   = {{2{cfg.target_temp[15]}}, cfg.target_temp};
    assign warm_x  = {{2{cfg.warm_level[15]}}, cfg.warm_level};
    assign near_lo = tgt_x - {3'b000, cfg.warmup_span};
    assign band_lo = tgt_x - {3'b000, cfg.hysteresis};
    assign band_hi = tgt_x + {3'b000, cfg.hysteresis};
    assign near    = t_x >= near_lo;

    // Heater: forced on below preheat zone, else hysteresis around target
    always_comb begin
        priority if (!near) begin
            n_heater = 1'b1;
        end else if (r_heater) begin
            n_heater = !(t_x >= band_hi);
        end else begin
            n_heater = t_x < band_lo;
        end
    end

    // Sticky warm flag
    assign n_warm = r_warm || (t_x >= warm_x);

    // Settle detector
    assign settle_req.step    = advance;
    assign settle_req.near    = near;
    assign settle_req.in_band = t_x >= band_lo;
    assign settle_req.temp    = r_in_temp;

    hbbsd_settle #(
        .SLOPE_WINDOW (SLOPE_WINDOW)
    ) u_settle (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (settle_req),
        .i_slope_limit   (cfg.slope_limit),
        .i_timeout_ticks (cfg.timeout_ticks),
        .o_ready_next    (ready_next)
    );

    // Controller state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heater    <= 1'b0;
            r_warm      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_heater <= n_heater;
                r_warm   <= n_warm;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_heater <= n_heater;
            r_out_warm   <= n_warm;
            r_out_ready  <= ready_next;
            r_out_near   <= near;
        end
    end

    assign o_heater_on  = r_out_heater;
    assign o_warm       = r_out_warm;
    assign o_ready_res  = r_out_ready;
    assign o_near_setpt = r_out_near;

endmodule

FILE: tb/heater_flag_checker.sv
// ----------------------------------------------------------------------------
// heater_flag_checker
// Watches the configuration port and both transaction channels of the heater
// controller. Keeps its own copy of the controller state, predicts the flags
// for every accepted tick and compares each result transaction, field by
// field, against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module heater_flag_checker #(
    parameter int SLOPE_WINDOW = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hbbsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hbbsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic signed [15:0]               i_temperature,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic                             i_heater_on,
    input  logic                             i_warm,
    input  logic                             i_ready_res,
    input  logic                             i_near_setpt,
    output int                               o_mismatches,
    output int                               o_pending,
    output int                               o_checked
);

    typedef struct packed {
        logic heater_on;
        logic warm;
        logic ready_res;
        logic near_setpt;
    } t_tick_flags;

    // Flags predicted for ticks whose result has not come out yet
    t_tick_flags expected_flags[$];

    // Shadow configuration
    logic signed [15:0] target_c;
    logic [14:0]        margin_c;
    logic [14:0]        hyst_c;
    logic signed [15:0] warm_lvl_c;
    logic [15:0]        slope_lim_c;
    logic [15:0]        timeout_c;

    // Shadow controller state
    logic heater_q;
    logic warm_q;
    logic ready_q;
    int   delta_log[SLOPE_WINDOW];
    int   hist_ptr;
    int   hist_fill;
    int   last_near_temp;
    logic last_near_seen;
    int   tick_ctr;

    task automatic report_mismatch(input string msg);
        $display("%0t ns  MISMATCH  %s", $time, msg);
        o_mismatches++;
    endtask

    task automatic check_field(input string name, input logic got, input logic want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is %b, expected %b",
                                      o_checked, name, got, want));
    endtask

    // One control tick: heater, warm, slope window, ready, tick count
    function automatic t_tick_flags predict_tick(input logic signed [15:0] temp);
        int          t;
        int          near_lo;
        int          band_lo;
        int          band_hi;
        int          mag;
        int          i;
        logic        near;
        logic        window_calm;
        t_tick_flags f;
        t       = temp;
        // thresholds at full precision, no 16 bit wrap
        near_lo = int'(target_c) - int'(margin_c);
        band_lo = int'(target_c) - int'(hyst_c);
        band_hi = int'(target_c) + int'(hyst_c);
        near    = (t >= near_lo);

        if (!near)
            heater_q = 1'b1;
        else if (heater_q) begin
            if (t >= band_hi) heater_q = 1'b0;
        end else begin
            if (t < band_lo) heater_q = 1'b1;
        end

        if (t >= int'(warm_lvl_c)) warm_q = 1'b1;

        // record deltas between successive near-target samples
        if (!ready_q && near) begin
            if (last_near_seen) begin
                delta_log[hist_ptr] = t - last_near_temp;
                hist_ptr = (hist_ptr + 1) % SLOPE_WINDOW;
                if (hist_fill < SLOPE_WINDOW) hist_fill++;
            end
            last_near_temp = t;
            last_near_seen = 1'b1;
        end

        if (!ready_q) begin
            window_calm = (hist_fill == SLOPE_WINDOW);
            for (i = 0; i < SLOPE_WINDOW; i++) begin
                mag = (delta_log[i] < 0) ? -delta_log[i] : delta_log[i];
                if (mag >= int'(slope_lim_c)) window_calm = 1'b0;
            end
            if (((t >= band_lo) && window_calm) || (tick_ctr >= int'(timeout_c)))
                ready_q = 1'b1;
        end

        if (tick_ctr < int'(hbbsd_pkg::TICK_MAX)) tick_ctr++;

        f.heater_on  = heater_q;
        f.warm       = warm_q;
        f.ready_res  = ready_q;
        f.near_setpt = near;
        return f;
    endfunction

    // Channel monitor: results first, then register writes, then new ticks
    always @(posedge i_clk) begin : watch_channels
        t_tick_flags got;
        t_tick_flags want;
        int          i;
        if (!i_rst_n) begin
            target_c       = hbbsd_pkg::RST_TARGET_TEMP;
            margin_c       = hbbsd_pkg::RST_WARMUP_SPAN;
            hyst_c         = hbbsd_pkg::RST_HYSTERESIS;
            warm_lvl_c     = hbbsd_pkg::RST_WARM_LEVEL;
            slope_lim_c    = hbbsd_pkg::RST_SLOPE_LIMIT;
            timeout_c      = hbbsd_pkg::RST_TIMEOUT_TICKS;
            heater_q       = 1'b0;
            warm_q         = 1'b0;
            ready_q        = 1'b0;
            for (i = 0; i < SLOPE_WINDOW; i++) delta_log[i] = 0;
            hist_ptr       = 0;
            hist_fill      = 0;
            last_near_temp = 0;
            last_near_seen = 1'b0;
            tick_ctr       = 0;
            expected_flags.delete();
            o_mismatches   = 0;
            o_checked      = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = {i_heater_on, i_warm, i_ready_res, i_near_setpt};
                if (expected_flags.size() == 0) begin
                    report_mismatch($sformatf("result with no tick outstanding: %b", got));
                end else begin
                    want = expected_flags.pop_front();
                    check_field("heater_on", got.heater_on, want.heater_on);
                    check_field("warm", got.warm, want.warm);
                    check_field("ready_res", got.ready_res, want.ready_res);
                    check_field("near_setpt", got.near_setpt, want.near_setpt);
                end
                o_checked++;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    hbbsd_pkg::CFG_TARGET_TEMP:    target_c    = i_cfg_data[15:0];
                    hbbsd_pkg::CFG_WARMUP_SPAN:    margin_c    = i_cfg_data[14:0];
                    hbbsd_pkg::CFG_HYSTERESIS:     hyst_c      = i_cfg_data[14:0];
                    hbbsd_pkg::CFG_WARM_LEVEL:     warm_lvl_c  = i_cfg_data[15:0];
                    hbbsd_pkg::CFG_SLOPE_LIMIT:    slope_lim_c = i_cfg_data[15:0];
                    hbbsd_pkg::CFG_TIMEOUT_TICKS:  timeout_c   = i_cfg_data[15:0];
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready)
                expected_flags.push_back(predict_tick(i_temperature));
        end
        o_pending = expected_flags.size();
    end

endmodule

FILE: tb/heater_bang_bang_with_settle_detect_top_tb.sv
// ----------------------------------------------------------------------------
// heater_bang_bang_with_settle_detect_top_tb
// Drives control ticks into the heater controller and applies a series of
// register settings between phases. A short directed part hits the extreme
// temperatures and thresholds; random phases follow with full-range noise and
// random walks around the hysteresis band that fill the slope window with
// deltas on both sides of the limit. Both channels idle at random. The
// checker predicts and compares every result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module heater_bang_bang_with_settle_detect_top_tb;

    import hbbsd_pkg::*;

    localparam int SLOPE_WINDOW    = 6;
    localparam int RANDOM_PHASES   = 8;
    localparam int TICKS_PER_PHASE = 140;
    localparam int STALL_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 10;
    localparam int WALK_SPAN       = 300;

    // Indexes past the register map; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum logic {SRC_NOISE, SRC_WALK} t_temp_source;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_in_valid    = 1'b0;
    logic signed [15:0]    i_temperature = '0;
    logic                  i_out_ready   = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_heater_on;
    logic                  o_warm;
    logic                  o_ready_res;
    logic                  o_near_setpt;

    int mismatches;
    int pending;
    int checked;

    int idle_pct  = 25;
    int stall_pct = 25;
    int ticks_sent;
    int settings_run;
    int stall_cycles;

    // Current phase setting, as the stimulus sees it
    int           cur_target;
    int           cur_hyst;
    int           cur_slope;
    t_temp_source cur_source;
    int           walk_temp;
    int           walk_center;

    heater_bang_bang_with_settle_detect_top #(
        .SLOPE_WINDOW (SLOPE_WINDOW)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_temperature (i_temperature),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_heater_on   (o_heater_on),
        .o_warm        (o_warm),
        .o_ready_res   (o_ready_res),
        .o_near_setpt  (o_near_setpt)
    );

    heater_flag_checker #(
        .SLOPE_WINDOW (SLOPE_WINDOW)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_temperature (i_temperature),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_heater_on   (o_heater_on),
        .i_warm        (o_warm),
        .i_ready_res   (o_ready_res),
        .i_near_setpt  (o_near_setpt),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side backpressure
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog: cycles with no transaction and no register write
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Register write; the enable drops only after the last of a burst
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input logic last);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        if (last) i_cfg_we <= 1'b0;
    endtask

    task automatic apply_config(input int target, input int margin, input int hyst,
                                input int warm, input int slope, input int timeout);
        cfg_write(CFG_TARGET_TEMP,    target[15:0],  1'b0);
        cfg_write(CFG_WARMUP_SPAN,    margin[15:0],  1'b0);
        cfg_write(CFG_HYSTERESIS,     hyst[15:0],    1'b0);
        cfg_write(CFG_WARM_LEVEL,     warm[15:0],    1'b0);
        cfg_write(CFG_SLOPE_LIMIT,    slope[15:0],   1'b0);
        cfg_write(CFG_TIMEOUT_TICKS,  timeout[15:0], 1'b1);
        cur_target  = $signed(target[15:0]);
        cur_hyst    = hyst[14:0];
        cur_slope   = slope[15:0];
        walk_center = cur_target - cur_hyst;
        if (walk_center < -32768) walk_center = -32768;
        walk_temp   = walk_center;
        settings_run++;
    endtask

    // One tick transaction; entered and left at a falling edge
    task automatic send_tick(input logic signed [15:0] temp);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_temperature <= temp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        ticks_sent++;
    endtask

    // Stop sending and wait until every predicted result has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] noise_temp();
        logic signed [15:0] v;
        v = 16'($urandom());
        return v;
    endfunction

    // Random walk around the band floor; outside the noise jumps, half the steps break a nonzero slope limit
    function automatic logic signed [15:0] walk_step();
        int step;
        if ($urandom_range(0, 99) < 15) return noise_temp();
        if (cur_slope == 0)
            step = $urandom_range(0, 20);
        else if ($urandom_range(0, 1))
            step = $urandom_range(0, cur_slope - 1);
        else
            step = $urandom_range(cur_slope, cur_slope + 3);
        if ($urandom_range(0, 1)) step = -step;
        walk_temp = walk_temp + step;
        if (walk_temp > walk_center + WALK_SPAN || walk_temp < walk_center - WALK_SPAN)
            walk_temp = walk_center;
        if (walk_temp > 32767) walk_temp = 32767;
        if (walk_temp < -32768) walk_temp = -32768;
        return walk_temp[15:0];
    endfunction

    initial begin : stimulus
        int phase;
        int n;
        int target;
        int margin;
        int hyst;
        int slope;
        int timeout;

        ticks_sent   = 0;
        settings_run = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset setting: below warm, preheat edge, band edges, warm level
        send_tick(-16'sd32768);
        send_tick(16'sd0);
        send_tick(16'sd3799);
        send_tick(16'sd4799);
        send_tick(16'sd4800);
        send_tick(16'sd5499);
        send_tick(16'sd5700);
        send_tick(16'sd5600);
        send_tick(16'sd5499);
        send_tick(16'sd3800);
        send_tick(16'sd32767);
        drain();

        // Writes past the register map, then lowest target with widest bands
        cfg_write(CFG_SPARE_LO, 16'hFFFF, 1'b0);
        cfg_write(CFG_SPARE_HI, 16'h0000, 1'b1);
        apply_config(-32768, 32'h7FFF, 32'h7FFF, 32767, 0, 65535);
        send_tick(-16'sd32768);
        send_tick(-16'sd1);
        send_tick(16'sd0);
        send_tick(16'sd32767);
        drain();

        // Highest target, zero band; margin has its unused top bit set
        apply_config(32767, 32'hFFFF, 0, -32768, 0, 65535);
        send_tick(16'sd32766);
        send_tick(16'sd32767);
        send_tick(-16'sd32768);
        send_tick(16'sd32767);
        send_tick(16'sd0);
        drain();

        // Random phases; the tick counter never reaches the timeout until the last
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            idle_pct   = 25;
            stall_pct  = 25;
            cur_source = SRC_WALK;
            target     = int'($urandom_range(0, 10000)) - 2000;
            margin     = $urandom_range(500, 2000) | ($urandom_range(0, 1) << 15);
            hyst       = $urandom_range(0, 200);
            slope      = 0;
            timeout    = 65535;
            case (phase)
                0: begin
                    target     = $urandom();
                    margin     = $urandom();
                    hyst       = $urandom();
                    cur_source = SRC_NOISE;
                end
                1: begin
                    // long stretch with both sides always willing
                    idle_pct  = 0;
                    stall_pct = 0;
                    margin    = $urandom_range(300, 2000);
                    hyst      = $urandom_range(0, 300);
                end
                2: begin
                    margin = 0;
                    hyst   = 0;
                end
                3: slope = $urandom_range(5, 40);
                4: slope = $urandom_range(1, 10);
                5: begin
                    slope = 1;
                    hyst  = $urandom_range(0, 50);
                end
                6: begin
                    margin     = $urandom();
                    hyst       = $urandom();
                    slope      = 65535;
                    cur_source = SRC_NOISE;
                end
                default: begin
                    slope   = $urandom_range(0, 30);
                    timeout = 0;
                end
            endcase
            apply_config(target, margin, hyst, $urandom(), slope, timeout);
            for (n = 0; n < TICKS_PER_PHASE; n++) begin
                if (cur_source == SRC_NOISE) send_tick(noise_temp());
                else                         send_tick(walk_step());
            end
            drain();
        end

        // Results all in; a few more cycles to catch anything extra
        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("ran %0d ticks across %0d register settings, %0d results compared",
                 ticks_sent, settings_run, checked);
        $display("covered noise, slope-window walks, zero and extreme limits, timeout");
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: heater_bang_bang_with_settle_detect_top.f
hw/rtl/hbbsd_pkg.sv
hw/rtl/hbbsd_cfg_regs.sv
hw/rtl/hbbsd_settle.sv
hw/rtl/heater_bang_bang_with_settle_detect_top.sv
tb/heater_flag_checker.sv
tb/heater_bang_bang_with_settle_detect_top_tb.sv
